// ----- design/alrs_pkg.sv -----
// shared types, register indexes and constants of the alarm ring and snooze controller
package alrs_pkg;

  localparam int unsigned RING_COUNT_WIDTH_DEF = 16;

  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned SNOOZE_W = 5;
  localparam int unsigned TICKS_W  = 16;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned RINGS_W  = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [MINUTE_W-1:0] MINUTE_LAST = 6'd59;
  localparam logic [HOUR_W-1:0]   HOUR_LAST_24 = 5'd23;
  localparam logic [HOUR_W-1:0]   HOUR_LAST_12 = 5'd12;
  localparam logic [HOUR_W-1:0]   HOUR_FIRST_12 = 5'd1;
  localparam logic [MINUTE_W:0]   MINUTES_PER_HOUR = 7'd60;
  localparam logic [RINGS_W-1:0]  LAST_SNOOZE_RING = 2'd2;
  localparam logic [RINGS_W-1:0]  FIRST_RING_DONE  = 2'd1;

  localparam logic [HOUR_W-1:0]   ALARM_HOUR_RST   = 5'd0;
  localparam logic [MINUTE_W-1:0] ALARM_MINUTE_RST = 6'd0;
  localparam logic                HOUR_MODE_RST    = 1'b1;
  localparam logic [SNOOZE_W-1:0] SNOOZE_RST       = 5'd5;
  localparam logic [TICKS_W-1:0]  RING_TICKS_RST   = 16'd60000;
  localparam logic [PERIOD_W-1:0] LED_PERIOD_RST   = 10'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALARM_HOUR   = 3'd0,
    REG_ALARM_MINUTE = 3'd1,
    REG_HOUR_MODE_24 = 3'd2,
    REG_SNOOZE_MIN   = 3'd3,
    REG_RING_TICKS   = 3'd4,
    REG_LED_PERIOD   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   alarm_hour;
    logic [MINUTE_W-1:0] alarm_minute;
    logic                hour_mode_24;
    logic [SNOOZE_W-1:0] snooze_minutes;
    logic [TICKS_W-1:0]  ring_ticks;
    logic [PERIOD_W-1:0] led_period;
  } cfg_t;

  typedef struct packed {
    logic                kind;
    logic                button_short;
    logic                time_update;
    logic [HOUR_W-1:0]   now_hour;
    logic [MINUTE_W-1:0] now_minute;
    logic [SECOND_W-1:0] now_second;
  } item_t;

  typedef struct packed {
    logic               buzzer_on;
    logic               led_phase;
    logic               alarm_flag;
    logic               finished;
    logic [RINGS_W-1:0] ring_index;
  } res_t;

endpackage

// ----- design/alrs_snooze_time.sv -----
// alarm time plus a minute offset, with hour wrap in 12- or 24-hour mode
module alrs_snooze_time
  import alrs_pkg::*;
(
  input  logic [HOUR_W-1:0]   alarm_hour,
  input  logic [MINUTE_W-1:0] alarm_minute,
  input  logic                hour_mode_24,
  input  logic [MINUTE_W-1:0] offset,
  output logic [HOUR_W-1:0]   snooze_hour,
  output logic [MINUTE_W-1:0] snooze_minute
);

  logic [MINUTE_W:0] sum;
  logic [MINUTE_W:0] wrapped;
  logic              carry;

  always_comb begin
    sum     = {1'b0, alarm_minute} + {1'b0, offset};
    carry   = (sum > {1'b0, MINUTE_LAST});
    wrapped = carry ? (sum - MINUTES_PER_HOUR) : sum;
    snooze_minute = wrapped[MINUTE_W-1:0];
    if (!carry) begin
      snooze_hour = alarm_hour;
    end else if (hour_mode_24) begin
      snooze_hour = (alarm_hour == HOUR_LAST_24) ? '0 : alarm_hour + 1'b1;
    end else begin
      snooze_hour = (alarm_hour == HOUR_LAST_12) ? HOUR_FIRST_12 : alarm_hour + 1'b1;
    end
  end

endmodule

// ----- design/alrs_ctrl.sv -----
// alarm state registers and the per-word ring, snooze and led update
module alrs_ctrl
  import alrs_pkg::*;
#(
  parameter int unsigned RING_COUNT_WIDTH = RING_COUNT_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step_en,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  localparam int unsigned CMP_W = (RING_COUNT_WIDTH > TICKS_W) ? RING_COUNT_WIDTH : TICKS_W;
  localparam logic [RING_COUNT_WIDTH-1:0] RING_MAX = '1;

  logic                        running_r, running_nxt;
  logic                        waiting_r, waiting_nxt;
  logic [RINGS_W-1:0]          rings_r, rings_nxt;
  logic [RING_COUNT_WIDTH-1:0] ring_cnt_r, ring_cnt_nxt;
  logic [PERIOD_W-1:0]         led_cnt_r, led_cnt_nxt;
  logic                        led_r, led_nxt;
  logic                        sound_r, sound_nxt;
  logic                        flag_r, flag_nxt;
  logic [HOUR_W-1:0]           snz1_hour_r, snz1_hour_nxt, snz2_hour_r, snz2_hour_nxt;
  logic [MINUTE_W-1:0]         snz1_min_r, snz1_min_nxt, snz2_min_r, snz2_min_nxt;

  logic [HOUR_W-1:0]   calc1_hour, calc2_hour;
  logic [MINUTE_W-1:0] calc1_min, calc2_min;
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W:0]   led_inc;
  logic [RING_COUNT_WIDTH-1:0] ring_inc;
  logic                hit;
  logic                fin;
  logic                start;

  alrs_snooze_time u_snz1 (
    .alarm_hour    (cfg.alarm_hour),
    .alarm_minute  (cfg.alarm_minute),
    .hour_mode_24  (cfg.hour_mode_24),
    .offset        ({1'b0, cfg.snooze_minutes}),
    .snooze_hour   (calc1_hour),
    .snooze_minute (calc1_min)
  );

  alrs_snooze_time u_snz2 (
    .alarm_hour    (cfg.alarm_hour),
    .alarm_minute  (cfg.alarm_minute),
    .hour_mode_24  (cfg.hour_mode_24),
    .offset        ({cfg.snooze_minutes, 1'b0}),
    .snooze_hour   (calc2_hour),
    .snooze_minute (calc2_min)
  );

  always_comb begin
    start = item.kind;
    // start re-initializes everything but the led phase
    running_nxt   = start ? 1'b1 : running_r;
    waiting_nxt   = start ? 1'b0 : waiting_r;
    rings_nxt     = start ? '0 : rings_r;
    ring_cnt_nxt  = start ? '0 : ring_cnt_r;
    led_cnt_nxt   = start ? '0 : led_cnt_r;
    sound_nxt     = start ? 1'b1 : sound_r;
    flag_nxt      = start ? 1'b1 : flag_r;
    snz1_hour_nxt = start ? calc1_hour : snz1_hour_r;
    snz1_min_nxt  = start ? calc1_min : snz1_min_r;
    snz2_hour_nxt = start ? calc2_hour : snz2_hour_r;
    snz2_min_nxt  = start ? calc2_min : snz2_min_r;
    led_nxt       = led_r;
    fin           = 1'b0;
    hit           = 1'b0;

    // zero period behaves as one
    period   = (cfg.led_period == '0) ? PERIOD_W'(1) : cfg.led_period;
    led_inc  = {1'b0, led_cnt_nxt} + 1'b1;
    ring_inc = (ring_cnt_nxt < RING_MAX) ? ring_cnt_nxt + 1'b1 : ring_cnt_nxt;

    if (running_nxt) begin
      if (led_cnt_nxt == '0 || led_cnt_nxt >= period) begin
        led_nxt = ~led_r;
      end
      led_cnt_nxt = (led_inc >= {1'b0, period}) ? '0 : led_inc[PERIOD_W-1:0];

      if (!waiting_nxt) begin
        ring_cnt_nxt = ring_inc;
        if (CMP_W'(ring_inc) >= CMP_W'(cfg.ring_ticks) || item.button_short) begin
          ring_cnt_nxt = '0;
          sound_nxt    = 1'b0;
          if (rings_nxt < LAST_SNOOZE_RING) begin
            waiting_nxt = 1'b1;
          end else begin
            flag_nxt    = 1'b0;
            running_nxt = 1'b0;
            fin         = 1'b1;
          end
          rings_nxt = rings_nxt + 1'b1;
        end
      end else begin
        if (item.time_update && item.now_second == '0) begin
          if (rings_nxt == FIRST_RING_DONE) begin
            hit = (snz1_hour_nxt == item.now_hour) && (snz1_min_nxt == item.now_minute);
          end else if (rings_nxt == LAST_SNOOZE_RING) begin
            hit = (snz2_hour_nxt == item.now_hour) && (snz2_min_nxt == item.now_minute);
          end
        end
        if (hit) begin
          flag_nxt     = 1'b1;
          waiting_nxt  = 1'b0;
          sound_nxt    = 1'b1;
          ring_cnt_nxt = '0;
        end
        // a press while waiting ends the alarm, even on a snooze match
        if (item.button_short) begin
          flag_nxt    = 1'b0;
          sound_nxt   = 1'b0;
          running_nxt = 1'b0;
          fin         = 1'b1;
        end
      end
    end else begin
      sound_nxt = 1'b0;
    end

    res.buzzer_on  = sound_nxt;
    res.led_phase  = led_nxt;
    res.alarm_flag = flag_nxt;
    res.finished   = fin;
    res.ring_index = rings_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      waiting_r   <= 1'b0;
      rings_r     <= '0;
      ring_cnt_r  <= '0;
      led_cnt_r   <= '0;
      led_r       <= 1'b0;
      sound_r     <= 1'b0;
      flag_r      <= 1'b0;
      snz1_hour_r <= '0;
      snz1_min_r  <= '0;
      snz2_hour_r <= '0;
      snz2_min_r  <= '0;
    end else if (step_en) begin
      running_r   <= running_nxt;
      waiting_r   <= waiting_nxt;
      rings_r     <= rings_nxt;
      ring_cnt_r  <= ring_cnt_nxt;
      led_cnt_r   <= led_cnt_nxt;
      led_r       <= led_nxt;
      sound_r     <= sound_nxt;
      flag_r      <= flag_nxt;
      snz1_hour_r <= snz1_hour_nxt;
      snz1_min_r  <= snz1_min_nxt;
      snz2_hour_r <= snz2_hour_nxt;
      snz2_min_r  <= snz2_min_nxt;
    end
  end

endmodule

// ----- design/alarm_ring_snooze_controller_core.sv -----
// top level of the alarm ring and snooze controller: ports, config registers, word stages
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | kind, button_short, time_update, now_h/m/s
//   out_    | output    | out_valid/out_stall | buzzer_on, led_phase, alarm_flag, finished,
//           |           |                     | ring_index
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// one word per cycle sustained while out_stall is low; a taken word sits in the input
// register, then the state update and result register load share a cycle, and the
// result register drives the output
// synchronous active-low reset clears the alarm state, both stage valids and the configuration registers
// out_stall holds the result register; the input register still refills when the result
// register frees up in the same cycle, so in_stall rises only while both stages are full
module alarm_ring_snooze_controller_core
  import alrs_pkg::*;
#(
  parameter int unsigned RING_COUNT_WIDTH = RING_COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic                  in_button_short,
  input  logic                  in_time_update,
  input  logic [HOUR_W-1:0]     in_now_hour,
  input  logic [MINUTE_W-1:0]   in_now_minute,
  input  logic [SECOND_W-1:0]   in_now_second,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_buzzer_on,
  output logic                  out_led_phase,
  output logic                  out_alarm_flag,
  output logic                  out_finished,
  output logic [RINGS_W-1:0]    out_ring_index,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t  cfg_r;
  item_t item_r;
  logic  item_valid_r;
  res_t  res_r;
  logic  res_valid_r;
  res_t  res;
  logic  step_en;
  logic  in_take;

  // the held word steps the state when the result register is free or draining
  assign step_en  = item_valid_r && (!res_valid_r || !out_stall);
  assign in_stall = item_valid_r && !step_en;
  assign in_take  = in_valid && !in_stall;

  // configuration registers, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alarm_hour     <= ALARM_HOUR_RST;
      cfg_r.alarm_minute   <= ALARM_MINUTE_RST;
      cfg_r.hour_mode_24   <= HOUR_MODE_RST;
      cfg_r.snooze_minutes <= SNOOZE_RST;
      cfg_r.ring_ticks     <= RING_TICKS_RST;
      cfg_r.led_period     <= LED_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALARM_HOUR:   cfg_r.alarm_hour     <= cfg_wdata[HOUR_W-1:0];
        REG_ALARM_MINUTE: cfg_r.alarm_minute   <= cfg_wdata[MINUTE_W-1:0];
        REG_HOUR_MODE_24: cfg_r.hour_mode_24   <= cfg_wdata[0];
        REG_SNOOZE_MIN:   cfg_r.snooze_minutes <= cfg_wdata[SNOOZE_W-1:0];
        REG_RING_TICKS:   cfg_r.ring_ticks     <= cfg_wdata[TICKS_W-1:0];
        REG_LED_PERIOD:   cfg_r.led_period     <= cfg_wdata[PERIOD_W-1:0];
        default: ;  // writes past the last register are dropped
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take) begin
      item_valid_r <= 1'b1;
    end else if (step_en) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.kind         <= in_kind;
      item_r.button_short <= in_button_short;
      item_r.time_update  <= in_time_update;
      item_r.now_hour     <= in_now_hour;
      item_r.now_minute   <= in_now_minute;
      item_r.now_second   <= in_now_second;
    end
  end

  alrs_ctrl #(
    .RING_COUNT_WIDTH (RING_COUNT_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (step_en) begin
      res_valid_r <= 1'b1;
    end else if (!out_stall) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_valid      = res_valid_r;
  assign out_buzzer_on  = res_r.buzzer_on;
  assign out_led_phase  = res_r.led_phase;
  assign out_alarm_flag = res_r.alarm_flag;
  assign out_finished   = res_r.finished;
  assign out_ring_index = res_r.ring_index;

endmodule
